/* rtl/mme_pkg.sv */
// Package for the matrix multiply engine: field widths, opcodes, register
// indexes, the sequencer state type and the control word of the MAC pipeline.
// No dependencies.
`default_nettype none

package mme_pkg;

	// Fixed widths of the item fields and registers.
	localparam int ELEM_W    = 32;
	localparam int IDX_W     = 3;
	localparam int OP_W      = 2;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W     = 64;
	localparam int FRAC_W    = 16;

	// Opcodes of an input word.
	localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ERR,
		ST_WAIT
	} seq_state_t;

	// Control word that travels with each multiply through the pipeline.
	typedef struct packed {
		logic valid;
		logic first_k;
		logic last_k;
		logic last_elem;
		logic err;
	} mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/mme_store.sv */
// Element store: one synchronous memory with one write port and one read
// port whose data is registered. No dependencies.
`default_nettype none

module mme_store #(
	parameter int DEPTH = 64,
	parameter int DATA_W = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/mme_seq.sv */
// Sequencer of the matrix multiply engine: clamps the dimensions, checks the
// format and walks row, column and dot-product index. Uses mme_pkg.
`default_nettype none

module mme_seq #(
	parameter int MAX_DIM = 8,
	localparam int CNT_W = $clog2(MAX_DIM),
	localparam int DIM_W = $clog2(MAX_DIM + 1),
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [mme_pkg::OP_W-1:0] opcode,
	input  wire logic [mme_pkg::CFG_W-1:0] a_rows,
	input  wire logic [mme_pkg::CFG_W-1:0] a_cols,
	input  wire logic [mme_pkg::CFG_W-1:0] b_rows,
	input  wire logic [mme_pkg::CFG_W-1:0] b_cols,
	input  wire logic                    done,
	output logic                         busy,
	output mme_pkg::mac_ctl_t            ctl,
	output logic      [CNT_W-1:0]        row,
	output logic      [CNT_W-1:0]        col,
	output logic      [ADDR_W-1:0]       a_raddr,
	output logic      [ADDR_W-1:0]       b_raddr
);

	mme_pkg::seq_state_t state_q, state_d;
	logic [CNT_W-1:0] i_q, j_q, k_q;
	logic [DIM_W-1:0] ar, ac, br, bc;
	logic [CNT_W-1:0] i_last, j_last, k_last;
	logic             accept, compute, mismatch;
	logic             k_end, j_end, i_end;

	// A zero counts as one, a value above the maximum counts as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [mme_pkg::CFG_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if ((DIM_W + mme_pkg::CFG_W)'(r) > (DIM_W + mme_pkg::CFG_W)'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(r);
		end
		return d;
	endfunction

	// Dimensions and the last value of each index.
	always_comb begin
		ar = clamp_dim(a_rows);
		ac = clamp_dim(a_cols);
		br = clamp_dim(b_rows);
		bc = clamp_dim(b_cols);
		i_last = CNT_W'(ar - DIM_W'(1));
		j_last = CNT_W'(bc - DIM_W'(1));
		k_last = CNT_W'(ac - DIM_W'(1));
		mismatch = (ac != br);
	end

	assign busy    = (state_q != mme_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign compute = accept && (opcode == mme_pkg::OP_COMPUTE);
	assign k_end   = (k_q == k_last);
	assign j_end   = (j_q == j_last);
	assign i_end   = (i_q == i_last);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (compute) begin
					state_d = mismatch ? mme_pkg::ST_ERR : mme_pkg::ST_RUN;
				end
			end
			mme_pkg::ST_RUN: begin
				if (k_end && j_end && i_end) begin
					state_d = mme_pkg::ST_WAIT;
				end
			end
			mme_pkg::ST_ERR: begin
				state_d = mme_pkg::ST_WAIT;
			end
			mme_pkg::ST_WAIT: begin
				if (done) begin
					state_d = mme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: the control word and read addresses of the current step.
	always_comb begin
		ctl = '0;
		case (state_q)
			mme_pkg::ST_RUN: begin
				ctl.valid     = 1'b1;
				ctl.first_k   = (k_q == '0);
				ctl.last_k    = k_end;
				ctl.last_elem = j_end && i_end;
			end
			mme_pkg::ST_ERR: begin
				ctl.valid     = 1'b1;
				ctl.last_elem = 1'b1;
				ctl.err       = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
		row     = i_q;
		col     = j_q;
		a_raddr = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
		b_raddr = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Index counters: k innermost, then column, then row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (compute) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (state_q == mme_pkg::ST_RUN) begin
			if (!k_end) begin
				k_q <= k_q + CNT_W'(1);
			end else begin
				k_q <= '0;
				if (!j_end) begin
					j_q <= j_q + CNT_W'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/mme_mac.sv */
// Multiply-accumulate pipeline: multiply, floor to Q16.16, accumulate and
// saturate, then register the result word. Uses mme_pkg.
`default_nettype none

module mme_mac #(
	parameter int CNT_W = 3,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mme_pkg::mac_ctl_t                 ctl,
	input  wire logic        [CNT_W-1:0]           row,
	input  wire logic        [CNT_W-1:0]           col,
	input  wire logic signed [mme_pkg::ELEM_W-1:0] a_data,
	input  wire logic signed [mme_pkg::ELEM_W-1:0] b_data,
	output logic                                   result_valid,
	output logic signed      [mme_pkg::ELEM_W-1:0] prod_value,
	output logic             [mme_pkg::IDX_W-1:0]  prod_row,
	output logic             [mme_pkg::IDX_W-1:0]  prod_col,
	output logic                                   last_out,
	output logic                                   format_error
);

	localparam logic [mme_pkg::ACC_W-1:0] SAT_HI =
		(mme_pkg::ACC_W'(1) << (VALUE_WIDTH - 1)) - mme_pkg::ACC_W'(1);
	localparam logic [mme_pkg::ACC_W-1:0] SAT_LO = ~SAT_HI;

	mme_pkg::mac_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [CNT_W-1:0] row_s1, row_s2, row_s3;
	logic [CNT_W-1:0] col_s1, col_s2, col_s3;
	logic signed [mme_pkg::ACC_W-1:0] prod_s2;
	logic signed [mme_pkg::ACC_W-1:0] acc_s3;
	logic signed [mme_pkg::ACC_W-1:0] sat_val;

	// Control words follow the memory latency and each pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Indices of the product element travel along.
	always_ff @(posedge clk) begin
		row_s1 <= row;
		col_s1 <= col;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		row_s3 <= row_s2;
		col_s3 <= col_s2;
	end

	// Full Q32.32 product, floored to Q48.16 by an arithmetic shift.
	always_ff @(posedge clk) begin
		prod_s2 <= (mme_pkg::ACC_W'(a_data) * mme_pkg::ACC_W'(b_data)) >>> mme_pkg::FRAC_W;
	end

	// Accumulator restarts on the first term of each dot product.
	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_s3 <= ctl_s2.first_k ? prod_s2 : acc_s3 + prod_s2;
		end
	end

	// Saturate the finished sum to the configured value width.
	always_comb begin
		if (acc_s3 > $signed(SAT_HI)) begin
			sat_val = $signed(SAT_HI);
		end else if (acc_s3 < $signed(SAT_LO)) begin
			sat_val = $signed(SAT_LO);
		end else begin
			sat_val = acc_s3;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctl_s3.valid && (ctl_s3.last_k || ctl_s3.err);
		end
	end

	// Result word; an error word carries zero value and indices.
	always_ff @(posedge clk) begin
		if (ctl_s3.err) begin
			prod_value <= '0;
			prod_row   <= '0;
			prod_col   <= '0;
		end else begin
			prod_value <= mme_pkg::ELEM_W'(sat_val);
			prod_row   <= mme_pkg::IDX_W'(row_s3);
			prod_col   <= mme_pkg::IDX_W'(col_s3);
		end
		last_out     <= ctl_s3.last_elem;
		format_error <= ctl_s3.err;
	end

endmodule

`default_nettype wire

/* rtl/matrix_multiply_engine_unit.sv */
// Top level of the matrix multiply engine: configuration registers, the two
// element stores, the sequencer and the MAC pipeline.
// Depends on mme_pkg, mme_store, mme_seq and mme_mac.
//
//   Channel   Handshake              Word
//   input     start && !busy         opcode, elem_row, elem_col, elem_value
//   result    result_valid (strobe)  prod_value, prod_row, prod_col, last_out, format_error
//   config    cfg_we                 cfg_index, cfg_data
//
// Load words leave busy low and stream at one per cycle while busy is low. A
// compute word holds busy high until its last result goes out; the sequencer
// issues one read of each store per cycle, and four register stages (store
// read, multiply, accumulate, result) follow. A format error holds busy until
// its error word goes out. Reset clears the control state; store contents are
// undefined until loaded. Results are shown for one cycle and cannot be held.
`default_nettype none

module matrix_multiply_engine_unit #(
	parameter int MAX_DIM = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic        [mme_pkg::OP_W-1:0]       opcode,
	input  wire logic        [mme_pkg::IDX_W-1:0]      elem_row,
	input  wire logic        [mme_pkg::IDX_W-1:0]      elem_col,
	input  wire logic signed [mme_pkg::ELEM_W-1:0]     elem_value,
	output logic                                       result_valid,
	output logic signed      [mme_pkg::ELEM_W-1:0]     prod_value,
	output logic             [mme_pkg::IDX_W-1:0]      prod_row,
	output logic             [mme_pkg::IDX_W-1:0]      prod_col,
	output logic                                       last_out,
	output logic                                       format_error,
	input  wire logic                                  cfg_we,
	input  wire logic        [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [mme_pkg::CFG_W-1:0]      cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = $clog2(MAX_DIM + 1) + mme_pkg::IDX_W;

	logic [mme_pkg::CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic                      accept, in_range, we_a, we_b;
	logic [ADDR_W-1:0]         waddr, a_raddr, b_raddr;
	logic [mme_pkg::ELEM_W-1:0] a_rdata, b_rdata;
	mme_pkg::mac_ctl_t         ctl;
	logic [CNT_W-1:0]          row, col;
	logic                      done;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mme_pkg::CFG_RESET;
			a_cols_q <= mme_pkg::CFG_RESET;
			b_rows_q <= mme_pkg::CFG_RESET;
			b_cols_q <= mme_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mme_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				mme_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				mme_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				mme_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Load decode; a load outside the store is dropped.
	assign accept   = start && !busy;
	assign in_range = (CMP_W'(elem_row) < CMP_W'(MAX_DIM)) &&
	                  (CMP_W'(elem_col) < CMP_W'(MAX_DIM));
	assign we_a     = accept && in_range && (opcode == mme_pkg::OP_LOAD_A);
	assign we_b     = accept && in_range && (opcode == mme_pkg::OP_LOAD_B);
	assign waddr    = ADDR_W'(CNT_W'(elem_row)) * ADDR_W'(MAX_DIM) +
	                  ADDR_W'(CNT_W'(elem_col));

	mme_store #(
		.DEPTH  (DEPTH),
		.DATA_W (mme_pkg::ELEM_W)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mme_store #(
		.DEPTH  (DEPTH),
		.DATA_W (mme_pkg::ELEM_W)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// The run ends when the last result word goes out.
	assign done = result_valid && last_out;

	mme_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.opcode  (opcode),
		.a_rows  (a_rows_q),
		.a_cols  (a_cols_q),
		.b_rows  (b_rows_q),
		.b_cols  (b_cols_q),
		.done    (done),
		.busy    (busy),
		.ctl     (ctl),
		.row     (row),
		.col     (col),
		.a_raddr (a_raddr),
		.b_raddr (b_raddr)
	);

	mme_mac #(
		.CNT_W       (CNT_W),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.row          (row),
		.col          (col),
		.a_data       ($signed(a_rdata)),
		.b_data       ($signed(b_rdata)),
		.result_valid (result_valid),
		.prod_value   (prod_value),
		.prod_row     (prod_row),
		.prod_col     (prod_col),
		.last_out     (last_out),
		.format_error (format_error)
	);

endmodule

`default_nettype wire
